/* rtl/nas_pkg.sv */
// Package for the nodal admittance stamper: field widths, codes, command struct.
// Used by nas_front, nas_back and the top level; depends on nothing.
package nas_pkg;

   localparam int NODES_DEF = 64;
   localparam int FRAC_BITS_DEF = 16;
   localparam int NODE_W = 7;
   localparam int RC_W = 6;
   localparam int VAL_W = 32;
   localparam int MAG_W = 31;

   typedef enum logic [1:0] {
      MODE_LINE = 2'd0,
      MODE_SHUNT = 2'd1,
      MODE_XFMR = 2'd2,
      MODE_READ = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_BAD_NODE = 3'd1,
      ST_ZERO_IMP = 3'd2,
      ST_ZERO_RATIO = 3'd3,
      ST_SAT = 3'd4
   } status_type;

   // Classified command passed from the front end to the back end.
   typedef struct packed {
      mode_type mode;
      logic fail;
      status_type status;
      logic [NODE_W-1:0] a;
      logic [NODE_W-1:0] b;
      logic [MAG_W-1:0] res;
      logic [VAL_W-1:0] xr;
      logic [VAL_W-1:0] half;
      logic [VAL_W-1:0] shunt;
      logic [MAG_W-1:0] tap;
   } cmd_type;

endpackage

/* rtl/nas_front.sv */
// Front end of the nodal admittance stamper: accepts items, checks nodes, impedance
// and ratio, and queues the classified commands. Depends on nas_pkg.
module nas_front #(
   parameter int NODES = nas_pkg::NODES_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input logic [1:0] mode,
   input logic [nas_pkg::NODE_W-1:0] node_i,
   input logic [nas_pkg::NODE_W-1:0] node_j,
   input logic [nas_pkg::MAG_W-1:0] resistance,
   input logic [nas_pkg::VAL_W-1:0] reactance,
   input logic [nas_pkg::VAL_W-1:0] half_charging,
   input logic [nas_pkg::VAL_W-1:0] shunt_value,
   input logic [nas_pkg::MAG_W-1:0] tap_ratio,
   input logic [nas_pkg::RC_W-1:0] read_row,
   input logic [nas_pkg::RC_W-1:0] read_col,
   output logic cmd_valid,
   input logic cmd_ready,
   output nas_pkg::cmd_type cmd
);
   localparam int QD = 2;
   nas_pkg::cmd_type q_ff [QD];
   logic [1:0] cnt_ff, cnt_in;
   logic wp_ff, rp_ff;
   nas_pkg::cmd_type c;
   logic bad_i, bad_j, push, pop;

   always_comb begin
      bad_i = (node_i == '0) || (32'(node_i) > NODES);
      bad_j = (node_j == '0) || (32'(node_j) > NODES);
      c = '0;
      c.mode = nas_pkg::mode_type'(mode);
      c.res = resistance;
      c.xr = reactance;
      c.half = half_charging;
      c.shunt = shunt_value;
      c.tap = tap_ratio;
      c.status = nas_pkg::ST_OK;
      c.a = node_i - 7'd1;
      c.b = node_j - 7'd1;
      unique case (c.mode)
         nas_pkg::MODE_READ: begin
            c.a = {1'b0, read_row};
            c.b = {1'b0, read_col};
            if (32'(read_row) >= NODES || 32'(read_col) >= NODES) begin
               c.status = nas_pkg::ST_BAD_NODE;
            end
         end
         nas_pkg::MODE_SHUNT: begin
            if (bad_i) c.status = nas_pkg::ST_BAD_NODE;
         end
         default: begin
            priority if (bad_i || bad_j) c.status = nas_pkg::ST_BAD_NODE;
            else if (resistance == '0 && reactance == '0) c.status = nas_pkg::ST_ZERO_IMP;
            else if (c.mode == nas_pkg::MODE_XFMR && tap_ratio == '0)
               c.status = nas_pkg::ST_ZERO_RATIO;
            else c.status = nas_pkg::ST_OK;
         end
      endcase
      c.fail = (c.status != nas_pkg::ST_OK);
   end

   assign req_tready = (cnt_ff != 2'(QD));
   assign push = req_tvalid && req_tready;
   assign cmd_valid = (cnt_ff != '0);
   assign pop = cmd_valid && cmd_ready;
   assign cmd = q_ff[rp_ff];
   assign cnt_in = cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
      end
      if (push) q_ff[wp_ff] <= c;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'(QD))
      else $error("queue count out of range");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'(QD) |-> !push) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> !pop) else $error("pop from empty queue");
endmodule

/* rtl/nas_div.sv */
// Shared restoring divider: q = floor(num * 2^sh / den) saturated to 2^31-1.
// One quotient bit per cycle. Depends on nothing.
module nas_div (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [63:0] num,
   input logic [63:0] den,
   input logic [5:0] sh,
   output logic done,
   output logic [30:0] quo,
   output logic sat
);
   typedef enum logic [1:0] {S_IDLE, S_INT, S_FRAC} state_type;
   state_type state_ff;
   logic [63:0] den_ff, rem_ff, q_ff;
   logic [6:0] k_ff;
   logic [5:0] sh_ff;
   logic [64:0] rem2;
   logic qbig;

   assign rem2 = {rem_ff, 1'b0};
   assign qbig = (q_ff > 64'h7FFF_FFFF);
   assign quo = qbig ? 31'h7FFF_FFFF : q_ff[30:0];
   assign sat = qbig;

   // Integer part is done bit serially over 64 steps of the numerator, then
   // sh fraction steps with early exit once the quotient overflows.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done <= 1'b0;
      end else begin
         done <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_INT;
                  den_ff <= den;
                  rem_ff <= '0;
                  q_ff <= num;
                  k_ff <= 7'd64;
                  sh_ff <= sh;
               end
            end
            S_INT: begin
               if ({rem_ff[62:0], q_ff[63]} >= den_ff) begin
                  rem_ff <= {rem_ff[62:0], q_ff[63]} - den_ff;
                  q_ff <= {q_ff[62:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[62:0], q_ff[63]};
                  q_ff <= {q_ff[62:0], 1'b0};
               end
               k_ff <= k_ff - 7'd1;
               if (k_ff == 7'd1) state_ff <= S_FRAC;
            end
            default: begin
               if (sh_ff == '0 || qbig) begin
                  state_ff <= S_IDLE;
                  done <= 1'b1;
               end else begin
                  sh_ff <= sh_ff - 6'd1;
                  if (rem2 >= {1'b0, den_ff}) begin
                     rem_ff <= 64'(rem2 - {1'b0, den_ff});
                     q_ff <= {q_ff[62:0], 1'b1};
                  end else begin
                     rem_ff <= rem2[63:0];
                     q_ff <= {q_ff[62:0], 1'b0};
                  end
               end
            end
         endcase
      end
   end
endmodule

/* rtl/nas_back.sv */
// Back end: clearing pass, admittance divisions, and read-modify-write of the
// conductance and susceptance stores. Depends on nas_pkg and nas_div.
module nas_back #(
   parameter int NODES = nas_pkg::NODES_DEF,
   parameter int FRAC_BITS = nas_pkg::FRAC_BITS_DEF
) (
   input logic clock,
   input logic reset,
   input logic cmd_valid,
   output logic cmd_ready,
   input nas_pkg::cmd_type cmd,
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [71:0] rsp_tdata
);
   localparam int DEPTH = NODES * (NODES + 1) / 2;
   localparam int AW = $clog2(DEPTH);
   localparam int NW = $clog2(NODES) + 1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_SQ, S_DIV, S_DWAIT, S_RD, S_RDW, S_UPD, S_UPW, S_OUT
   } state_type;

   state_type state_ff;
   logic [31:0] gmem [DEPTH];
   logic [31:0] bmem [DEPTH];
   logic [31:0] grd_ff, brd_ff;
   logic [AW-1:0] addr_ff, clr_ff;
   nas_pkg::cmd_type c_ff;
   logic sat_ff;
   logic [2:0] div_ff;
   logic [2:0] up_ff;
   logic [63:0] den_ff;
   logic [30:0] gm_ff, bm_ff, gk_ff, bk_ff, gk2_ff, bk2_ff;
   logic [31:0] ax;
   logic [63:0] prod_ff;
   logic sq_ff;

   logic dv_start;
   logic [63:0] dv_num, dv_den;
   logic [5:0] dv_sh;
   logic dv_done, dv_sat;
   logic [30:0] dv_q;

   nas_div u_div (
      .clock(clock), .reset(reset), .start(dv_start), .num(dv_num),
      .den(dv_den), .sh(dv_sh), .done(dv_done), .quo(dv_q), .sat(dv_sat)
   );

   function automatic logic [AW-1:0] pos(input logic [NW-1:0] a, input logic [NW-1:0] b);
      logic [NW-1:0] r, c;
      logic [2*NW:0] p;
      r = (a > b) ? a : b;
      c = (a > b) ? b : a;
      p = ((2*NW+1)'(r) * (2*NW+1)'(r + NW'(1))) >> 1;
      return AW'(p + (2*NW+1)'(c));
   endfunction

   logic bneg;
   assign bneg = !c_ff.xr[31] && (c_ff.xr != '0);
   assign ax = c_ff.xr[31] ? (32'd0 - c_ff.xr) : c_ff.xr;

   // Division schedule: gm, bm, and in transformer mode gk, bk, gk2, bk2.
   always_comb begin
      dv_num = '0;
      dv_den = {33'd0, c_ff.tap};
      dv_sh = 6'(FRAC_BITS);
      unique case (div_ff)
         3'd0: begin dv_num = {33'd0, c_ff.res}; dv_den = den_ff; dv_sh = 6'(2*FRAC_BITS); end
         3'd1: begin dv_num = {32'd0, ax}; dv_den = den_ff; dv_sh = 6'(2*FRAC_BITS); end
         3'd2: dv_num = {33'd0, gm_ff};
         3'd3: dv_num = {33'd0, bm_ff};
         3'd4: dv_num = {33'd0, gk_ff};
         default: dv_num = {33'd0, bk_ff};
      endcase
   end
   assign dv_start = (state_ff == S_DIV);

   // Update step: address, target store and delta.
   logic [NW-1:0] ni, nj;
   logic [AW-1:0] u_addr;
   logic u_isb;
   logic signed [33:0] u_delta;
   logic signed [33:0] g_s, b_s, gk_s, bk_s, gk2_s, bk2_s, half_s;
   always_comb begin
      ni = NW'(c_ff.a);
      nj = NW'(c_ff.b);
      if (c_ff.mode == nas_pkg::MODE_READ) begin
         ni = NW'(c_ff.a);
         nj = NW'(c_ff.b);
      end
      g_s = 34'(gm_ff);
      b_s = bneg ? -34'(bm_ff) : 34'(bm_ff);
      gk_s = 34'(gk_ff);
      bk_s = bneg ? -34'(bk_ff) : 34'(bk_ff);
      gk2_s = 34'(gk2_ff);
      bk2_s = bneg ? -34'(bk2_ff) : 34'(bk2_ff);
      half_s = 34'(signed'(c_ff.half));
      u_addr = pos(ni, nj);
      u_isb = 1'b0;
      u_delta = '0;
      if (c_ff.mode == nas_pkg::MODE_SHUNT) begin
         u_addr = pos(ni, ni);
         u_isb = 1'b1;
         u_delta = 34'(signed'(c_ff.shunt));
      end else if (c_ff.mode == nas_pkg::MODE_LINE) begin
         unique case (up_ff)
            3'd0: begin u_addr = pos(ni, nj); u_delta = -g_s; end
            3'd1: begin u_addr = pos(ni, nj); u_isb = 1'b1; u_delta = -b_s; end
            3'd2: begin u_addr = pos(ni, ni); u_isb = 1'b1; u_delta = b_s + half_s; end
            3'd3: begin u_addr = pos(nj, nj); u_isb = 1'b1; u_delta = b_s + half_s; end
            3'd4: begin u_addr = pos(ni, ni); u_delta = g_s; end
            default: begin u_addr = pos(nj, nj); u_delta = g_s; end
         endcase
      end else begin
         unique case (up_ff)
            3'd0: begin u_addr = pos(ni, nj); u_delta = -gk_s; end
            3'd1: begin u_addr = pos(ni, nj); u_isb = 1'b1; u_delta = -bk_s; end
            3'd2: begin u_addr = pos(ni, ni); u_delta = gk2_s; end
            3'd3: begin u_addr = pos(ni, ni); u_isb = 1'b1; u_delta = bk2_s; end
            3'd4: begin u_addr = pos(nj, nj); u_delta = g_s; end
            default: begin u_addr = pos(nj, nj); u_isb = 1'b1; u_delta = b_s; end
         endcase
      end
   end

   logic signed [33:0] sum;
   logic sum_hi, sum_lo;
   logic [31:0] wval;
   assign sum = 34'(signed'(c_ff.mode == nas_pkg::MODE_READ ? grd_ff :
                (u_isb ? brd_ff : grd_ff))) + u_delta;
   assign sum_hi = sum > 34'sh0_7FFF_FFFF;
   assign sum_lo = sum < -34'sh0_8000_0000;
   assign wval = sum_hi ? 32'h7FFF_FFFF : (sum_lo ? 32'h8000_0000 : sum[31:0]);

   logic last_up;
   assign last_up = (c_ff.mode == nas_pkg::MODE_SHUNT) || (up_ff == 3'd5);
   logic [2:0] last_div;
   assign last_div = (c_ff.mode == nas_pkg::MODE_XFMR) ? 3'd5 : 3'd1;

   assign cmd_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_tvalid <= 1'b0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (32'(clr_ff) == DEPTH - 1) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (cmd_valid) begin
                  c_ff <= cmd;
                  sat_ff <= 1'b0;
                  div_ff <= '0;
                  up_ff <= '0;
                  sq_ff <= 1'b0;
                  if (cmd.fail) begin
                     rsp_tdata <= {5'd0, cmd.status, 64'd0};
                     rsp_tvalid <= 1'b1;
                     state_ff <= S_OUT;
                  end else if (cmd.mode == nas_pkg::MODE_READ) begin
                     addr_ff <= pos(NW'(cmd.a), NW'(cmd.b));
                     state_ff <= S_RD;
                  end else if (cmd.mode == nas_pkg::MODE_SHUNT) begin
                     state_ff <= S_RD;
                  end else begin
                     state_ff <= S_SQ;
                  end
               end
            end
            S_SQ: begin
               // r*r then x*x, one 32x32 product per cycle.
               sq_ff <= ~sq_ff;
               if (!sq_ff) begin
                  prod_ff <= 64'(c_ff.res) * 64'(c_ff.res);
               end else begin
                  den_ff <= prod_ff + 64'(ax) * 64'(ax);
                  state_ff <= S_DIV;
               end
            end
            S_DIV: state_ff <= S_DWAIT;
            S_DWAIT: begin
               if (dv_done) begin
                  if (dv_sat) sat_ff <= 1'b1;
                  unique case (div_ff)
                     3'd0: gm_ff <= dv_q;
                     3'd1: bm_ff <= dv_q;
                     3'd2: gk_ff <= dv_q;
                     3'd3: bk_ff <= dv_q;
                     3'd4: gk2_ff <= dv_q;
                     default: bk2_ff <= dv_q;
                  endcase
                  div_ff <= div_ff + 3'd1;
                  state_ff <= (div_ff == last_div) ? S_RD : S_DIV;
               end
            end
            S_RD: begin
               if (c_ff.mode != nas_pkg::MODE_READ) addr_ff <= u_addr;
               state_ff <= S_RDW;
            end
            S_RDW: begin
               if (c_ff.mode == nas_pkg::MODE_READ) begin
                  state_ff <= S_OUT;
                  rsp_tvalid <= 1'b1;
                  rsp_tdata <= {5'd0, nas_pkg::ST_OK, brd_ff, grd_ff};
               end else begin
                  state_ff <= S_UPD;
               end
            end
            S_UPD: begin
               if (sum_hi || sum_lo) sat_ff <= 1'b1;
               state_ff <= S_UPW;
            end
            S_UPW: begin
               if (last_up) begin
                  state_ff <= S_OUT;
                  rsp_tvalid <= 1'b1;
                  rsp_tdata <= {5'd0, sat_ff ? nas_pkg::ST_SAT : nas_pkg::ST_OK, 64'd0};
               end else begin
                  up_ff <= up_ff + 3'd1;
                  state_ff <= S_RD;
               end
            end
            default: begin
               if (rsp_tready) begin
                  rsp_tvalid <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
         endcase
      end
   end

   // Store port: reads registered in S_RD's successor, writes in S_UPD or the
   // clearing pass.
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         gmem[clr_ff] <= '0;
         bmem[clr_ff] <= '0;
      end else if (state_ff == S_UPD) begin
         if (u_isb) bmem[addr_ff] <= wval;
         else gmem[addr_ff] <= wval;
      end
      grd_ff <= gmem[(state_ff == S_RD && c_ff.mode != nas_pkg::MODE_READ) ? u_addr : addr_ff];
      brd_ff <= bmem[(state_ff == S_RD && c_ff.mode != nas_pkg::MODE_READ) ? u_addr : addr_ff];
   end

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> state_ff == S_OUT) else $error("result shown outside output state");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_ready |-> !rsp_tvalid) else $error("taking command while result pending");
   a_up_range: assert property (@(posedge clock) disable iff (reset)
      up_ff <= 3'd5 || state_ff == S_IDLE || state_ff == S_CLEAR)
      else $error("update step out of range");
endmodule

/* rtl/nodal_admittance_stamper.sv */
// Nodal admittance stamper top level: front end with a two-entry command queue, back end.
// Line and transformer items use the bit-serial shared divider (64 integer steps plus
// the fraction steps per quotient), which stops early once a quotient saturates.
// One item is in the back end at a time and the queue holds two more; the back end takes
// the next item in the cycle after the result transfer. Synchronous reset; afterwards a
// clearing pass zeroes all NODES*(NODES+1)/2 entries of both stores before the first item.
module nodal_admittance_stamper #(
   parameter int NODES = nas_pkg::NODES_DEF,
   parameter int FRAC_BITS = nas_pkg::FRAC_BITS_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   // mode
   input logic [1:0] req_tuser,
   // node_i, node_j, resistance, reactance, half_charging, shunt_value,
   // tap_ratio, read_row, read_col
   input logic [183:0] req_tdata,
   output logic rsp_tvalid,
   input logic rsp_tready,
   // conductance_out, susceptance_out, status
   output logic [71:0] rsp_tdata
);
   logic cmd_valid, cmd_ready;
   nas_pkg::cmd_type cmd;

   nas_front #(.NODES(NODES)) u_front (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .mode(req_tuser), .node_i(req_tdata[6:0]), .node_j(req_tdata[13:7]),
      .resistance(req_tdata[44:14]), .reactance(req_tdata[76:45]),
      .half_charging(req_tdata[108:77]), .shunt_value(req_tdata[140:109]),
      .tap_ratio(req_tdata[171:141]), .read_row(req_tdata[177:172]),
      .read_col(req_tdata[183:178]),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
   );

   nas_back #(.NODES(NODES), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
      .cmd(cmd), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );
endmodule
